/* hw/rtl/dpse_pkg.sv */
// Shared types and constants for the EVENODD stripe encoder.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package dpse_pkg;

  // Largest prime stripe width and lane count of one symbol
  localparam int MAX_P       = 17;
  localparam int SYMBOL_BITS = 64;

  // Port widths fixed by the interface
  localparam int WORD_W = 64;
  localparam int P_W    = 5;
  localparam int IDX_W  = 4;

  // Accumulator depths and their index widths
  localparam int ROW_DEPTH  = MAX_P - 1;
  localparam int DIAG_DEPTH = MAX_P;
  localparam int RIDX_W     = $clog2(ROW_DEPTH);
  localparam int DIDX_W     = $clog2(DIAG_DEPTH);

  localparam logic [P_W-1:0] P_MIN = P_W'(3);
  localparam logic [P_W-1:0] P_MAX = P_W'(MAX_P);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_SFETCH,
    ST_DIAGS
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              acc;        // fold the input symbol into both accumulators
    logic [RIDX_W-1:0] row_addr;
    logic [DIDX_W-1:0] diag_addr;
    logic              load_s;     // capture the adjuster S
    logic              emit;       // present one parity word
    logic              emit_diag;  // word comes from the diagonal side
    logic [IDX_W-1:0]  out_idx;
    logic              last;
    logic              clear;      // zero all accumulators
  } dp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/dual_parity_stripe_encoder_core.sv */
// Top level of the EVENODD stripe encoder: controller plus datapath.
// Depends on dpse_pkg, dpse_ctrl and dpse_datapath.
//
//   channel   direction  handshake                 payload
//   symbol    in         start_i, busy_o           data_word_i
//   parity    out        parity_valid_o (strobe)   parity_word_o, parity_column_o,
//                                                  row_index_o, last_o
//   config    in         cfg_we_i                  cfg_wdata_i (prime_p)
//
// A symbol is taken while start_i is high and busy_o is low; symbols may arrive back to back within a stripe.
// After the last symbol of a stripe busy_o stays high while the block emits p-1
// row words, fetches the adjuster from the single diagonal read port in ST_SFETCH,
// then emits p-1 diagonal words. Each word appears in the cycle after it is read.
// Reset clears all accumulators at once and sets prime_p to 5. The receiver
// cannot stall; every strobed word is taken.
`default_nettype none

module dual_parity_stripe_encoder_core
  import dpse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [WORD_W-1:0] data_word_i,
  input  wire logic              cfg_we_i,
  input  wire logic [P_W-1:0]    cfg_wdata_i,
  output logic                   parity_valid_o,
  output logic [WORD_W-1:0]      parity_word_o,
  output logic                   parity_column_o,
  output logic [IDX_W-1:0]       row_index_o,
  output logic                   last_o
);

  dp_cmd_t cmd;

  // Sequence the stripe
  dpse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .busy_o     (busy_o),
    .cmd_o      (cmd)
  );

  // Accumulate and emit parity
  dpse_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_word_i    (data_word_i),
    .parity_valid_o (parity_valid_o),
    .parity_word_o  (parity_word_o),
    .parity_column_o(parity_column_o),
    .row_index_o    (row_index_o),
    .last_o         (last_o)
  );

  // A parity word only follows a cycle of emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    parity_valid_o |-> $past(busy_o))
    else $error("parity word without a busy cycle before it");

  // The stripe ends on a diagonal word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> (parity_valid_o && parity_column_o))
    else $error("last flag on a row parity word");

  // An accepted symbol is never followed directly by a parity word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cfg_we_i) |=> !parity_valid_o)
    else $error("parity word right after an accepted transaction");

endmodule

`default_nettype wire

/* hw/rtl/dpse_ctrl.sv */
// Controller of the stripe encoder: prime register, row/column/diagonal
// counters and the emission sequencer. Depends on dpse_pkg.
`default_nettype none

module dpse_ctrl
  import dpse_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           cfg_we_i,
  input  wire logic [P_W-1:0] cfg_wdata_i,
  output logic                busy_o,
  output dp_cmd_t             cmd_o
);

  state_e         state_q, state_d;
  logic [P_W-1:0] prime_q;
  logic [P_W-1:0] r_q, r_d;
  logic [P_W-1:0] c_q, c_d;
  logic [P_W-1:0] dg_q, dg_d;
  logic [P_W-1:0] k_q, k_d;
  logic [P_W-1:0] p_eff;
  logic [P_W-1:0] p_m1;
  logic [P_W-1:0] p_m2;
  logic           accept;

  // Saturate the programmed width into the supported range
  always_comb begin
    if (prime_q < P_MIN) begin
      p_eff = P_MIN;
    end else if (prime_q > P_MAX) begin
      p_eff = P_MAX;
    end else begin
      p_eff = prime_q;
    end
  end

  assign p_m1   = p_eff - P_W'(1);
  assign p_m2   = p_eff - P_W'(2);
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Hold the prime register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= P_W'(5);
    end else if (cfg_we_i) begin
      prime_q <= cfg_wdata_i;
    end
  end

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      dg_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      dg_q    <= dg_d;
      k_q     <= k_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    dg_d    = dg_q;
    k_d     = k_q;

    cmd_o           = '0;
    cmd_o.row_addr  = r_q[RIDX_W-1:0];
    cmd_o.diag_addr = dg_q[DIDX_W-1:0];
    cmd_o.out_idx   = k_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.acc = 1'b1;
          if (r_q == p_m2) begin
            // Column done: start the next one, or finish the stripe
            r_d = '0;
            if (c_q == p_m1) begin
              c_d     = '0;
              dg_d    = '0;
              k_d     = '0;
              state_d = ST_ROWS;
            end else begin
              c_d  = c_q + P_W'(1);
              dg_d = c_q + P_W'(1);
            end
          end else begin
            r_d  = r_q + P_W'(1);
            dg_d = (dg_q == p_m1) ? '0 : dg_q + P_W'(1);
          end
        end
      end
      ST_ROWS: begin
        cmd_o.emit     = 1'b1;
        cmd_o.row_addr = k_q[RIDX_W-1:0];
        if (k_q == p_m2) begin
          k_d     = '0;
          state_d = ST_SFETCH;
        end else begin
          k_d = k_q + P_W'(1);
        end
      end
      ST_SFETCH: begin
        cmd_o.load_s    = 1'b1;
        cmd_o.diag_addr = p_m1[DIDX_W-1:0];
        state_d         = ST_DIAGS;
      end
      ST_DIAGS: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_diag = 1'b1;
        cmd_o.diag_addr = k_q[DIDX_W-1:0];
        if (k_q == p_m2) begin
          cmd_o.last  = 1'b1;
          cmd_o.clear = 1'b1;
          k_d         = '0;
          state_d     = ST_IDLE;
        end else begin
          k_d = k_q + P_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Drop any partial stripe on a configuration write
    if (cfg_we_i) begin
      cmd_o.acc   = 1'b0;
      cmd_o.emit  = 1'b0;
      cmd_o.clear = 1'b1;
      state_d     = ST_IDLE;
      r_d         = '0;
      c_d         = '0;
      dg_d        = '0;
      k_d         = '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dpse_datapath.sv */
// Datapath of the stripe encoder: row and diagonal accumulators, adjuster
// register and the registered result stage. Depends on dpse_pkg.
`default_nettype none

module dpse_datapath
  import dpse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  input  wire logic [WORD_W-1:0] data_word_i,
  output logic                   parity_valid_o,
  output logic [WORD_W-1:0]      parity_word_o,
  output logic                   parity_column_o,
  output logic [IDX_W-1:0]       row_index_o,
  output logic                   last_o
);

  logic [SYMBOL_BITS-1:0] row_q  [ROW_DEPTH];
  logic [SYMBOL_BITS-1:0] diag_q [DIAG_DEPTH];
  logic [SYMBOL_BITS-1:0] s_q;
  logic [SYMBOL_BITS-1:0] sym;
  logic [SYMBOL_BITS-1:0] row_rd;
  logic [SYMBOL_BITS-1:0] diag_rd;
  logic [SYMBOL_BITS-1:0] word_d;
  logic [WORD_W-1:0]      word_q;
  logic                   valid_q;
  logic                   col_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   last_q;

  assign sym     = data_word_i[SYMBOL_BITS-1:0];
  assign row_rd  = row_q[cmd_i.row_addr];
  assign diag_rd = diag_q[cmd_i.diag_addr];
  assign word_d  = cmd_i.emit_diag ? (diag_rd ^ s_q) : row_rd;

  // Accumulate symbols; clear the whole stripe on command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROW_DEPTH; i++) begin
        row_q[i] <= '0;
      end
      for (int i = 0; i < DIAG_DEPTH; i++) begin
        diag_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < ROW_DEPTH; i++) begin
        row_q[i] <= '0;
      end
      for (int i = 0; i < DIAG_DEPTH; i++) begin
        diag_q[i] <= '0;
      end
    end else if (cmd_i.acc) begin
      row_q[cmd_i.row_addr]   <= row_rd ^ sym;
      diag_q[cmd_i.diag_addr] <= diag_rd ^ sym;
    end
  end

  // Capture the adjuster S
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_s) begin
      s_q <= diag_rd;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      word_q <= WORD_W'(word_d);
      col_q  <= cmd_i.emit_diag;
      idx_q  <= cmd_i.out_idx;
      last_q <= cmd_i.last;
    end
  end

  assign parity_valid_o  = valid_q;
  assign parity_word_o   = word_q;
  assign parity_column_o = col_q;
  assign row_index_o     = idx_q;
  assign last_o          = valid_q && last_q;

endmodule

`default_nettype wire
